/* hdl/embargo_pool_table_macros.svh */
// Assertion macros for the embargo pool table checker.
// Used by: ept_checker.sv.
`ifndef EMBARGO_POOL_TABLE_MACROS_SVH
`define EMBARGO_POOL_TABLE_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define EPT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define EPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ept_pkg.sv */
// Shared types and constants for the embargo pool table.
// No dependencies; used by every module of the block.
package ept_pkg;

   localparam int POOL_DEPTH_DEF = 16;
   localparam int KEY_W          = 256;
   localparam int WORD_W         = 64;
   localparam int DL_W           = 33;
   localparam int TIME_W         = 32;
   localparam int EMB_W          = 16;
   localparam int OCC_W          = 5;
   localparam int MAXC_W         = 5;
   localparam logic [MAXC_W-1:0] MAX_EMIT = 5'd16;
   localparam logic [EMB_W-1:0]  EMBARGO_RESET = 16'd30;

   localparam logic [1:0] REQ_ADD      = 2'd0;
   localparam logic [1:0] REQ_REMOVE   = 2'd1;
   localparam logic [1:0] REQ_CONTAINS = 2'd2;
   localparam logic [1:0] REQ_EXPIRE   = 2'd3;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_DUP      = 2'd1;
   localparam logic [1:0] ST_EVICTED  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_CMP,
      S_DECIDE,
      S_CNT_DONE,
      S_EMIT_RD,
      S_EMIT_CMP
   } state_type;

   typedef struct packed {
      logic load_req;
      logic clr_scan;
      logic next_slot;
      logic eval_lookup;
      logic eval_count;
      logic eval_emit;
      logic finish_single;
   } cmd_type;

   typedef struct packed {
      logic is_expire;
      logic last_slot;
      logic n_zero;
      logic emit_hit;
      logic emit_last;
      logic rsp_free;
   } stat_type;

endpackage

/* hdl/ept_ctrl.sv */
// Controller state machine for the embargo pool table.
// Depends on ept_pkg; drives ept_datapath through cmd_type.
module ept_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ept_pkg::stat_type stat,
   output ept_pkg::cmd_type  cmd
);

   ept_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ept_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ept_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ept_pkg::S_RD;
            end
         end
         ept_pkg::S_RD: begin
            state_in = ept_pkg::S_CMP;
         end
         ept_pkg::S_CMP: begin
            if (stat.is_expire) begin
               cmd.eval_count = 1'b1;
            end else begin
               cmd.eval_lookup = 1'b1;
            end
            if (stat.last_slot) begin
               state_in = stat.is_expire ? ept_pkg::S_CNT_DONE : ept_pkg::S_DECIDE;
            end else begin
               cmd.next_slot = 1'b1;
               state_in      = ept_pkg::S_RD;
            end
         end
         ept_pkg::S_DECIDE: begin
            if (stat.rsp_free) begin
               cmd.finish_single = 1'b1;
               state_in          = ept_pkg::S_IDLE;
            end
         end
         ept_pkg::S_CNT_DONE: begin
            if (stat.n_zero) begin
               if (stat.rsp_free) begin
                  cmd.finish_single = 1'b1;
                  state_in          = ept_pkg::S_IDLE;
               end
            end else begin
               cmd.clr_scan = 1'b1;
               state_in     = ept_pkg::S_EMIT_RD;
            end
         end
         ept_pkg::S_EMIT_RD: begin
            state_in = ept_pkg::S_EMIT_CMP;
         end
         ept_pkg::S_EMIT_CMP: begin
            if (stat.emit_hit) begin
               if (stat.rsp_free) begin
                  cmd.eval_emit = 1'b1;
                  if (stat.emit_last) begin
                     state_in = ept_pkg::S_IDLE;
                  end else begin
                     cmd.next_slot = 1'b1;
                     state_in      = ept_pkg::S_EMIT_RD;
                  end
               end
            end else begin
               cmd.next_slot = 1'b1;
               state_in      = ept_pkg::S_EMIT_RD;
            end
         end
         default: begin
            state_in = ept_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* hdl/ept_datapath.sv */
// Datapath for the embargo pool table: slot memories, live bits, scan
// registers and the result register. Depends on ept_pkg.
module ept_datapath #(
   parameter int POOL_DEPTH = ept_pkg::POOL_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ept_pkg::cmd_type                   cmd,
   output ept_pkg::stat_type                  stat,
   input  logic                               csr_wr_en,
   input  logic [ept_pkg::EMB_W-1:0]          csr_wr_data,
   input  logic [1:0]                         req_type,
   input  logic [ept_pkg::WORD_W-1:0]         req_key_w0,
   input  logic [ept_pkg::WORD_W-1:0]         req_key_w1,
   input  logic [ept_pkg::WORD_W-1:0]         req_key_w2,
   input  logic [ept_pkg::WORD_W-1:0]         req_key_w3,
   input  logic [ept_pkg::TIME_W-1:0]         req_now_secs,
   input  logic [ept_pkg::MAXC_W-1:0]         req_max_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_hit,
   output logic [ept_pkg::WORD_W-1:0]         rsp_out_w0,
   output logic [ept_pkg::WORD_W-1:0]         rsp_out_w1,
   output logic [ept_pkg::WORD_W-1:0]         rsp_out_w2,
   output logic [ept_pkg::WORD_W-1:0]         rsp_out_w3,
   output logic [ept_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic                               rsp_last
);

   localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int KW    = ept_pkg::KEY_W;
   localparam int DW    = ept_pkg::DL_W;
   localparam int MW    = ept_pkg::MAXC_W;
   localparam int WW    = ept_pkg::WORD_W;

   logic [KW-1:0] key_mem [POOL_DEPTH];
   logic [DW-1:0] dl_mem  [POOL_DEPTH];
   logic [KW-1:0] key_rd_ff;
   logic [DW-1:0] dl_rd_ff;

   logic [1:0]                  type_ff, type_in;
   logic [KW-1:0]               key_ff, key_in;
   logic [ept_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [MW-1:0]               lim_ff, lim_in;
   logic [ept_pkg::EMB_W-1:0]   emb_ff, emb_in;
   logic [POOL_DEPTH-1:0]       live_ff, live_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        found_ff, found_in;
   logic                        free_ff, free_in;
   logic [IDX_W-1:0]            found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]            old_idx_ff, old_idx_in;
   logic [DW-1:0]               old_dl_ff, old_dl_in;
   logic [MW-1:0]               n_ff, n_in;
   logic [MW-1:0]               emitted_ff, emitted_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [KW-1:0]               rsp_key_ff, rsp_key_in;
   logic [ept_pkg::OCC_W-1:0]   rsp_occ_ff, rsp_occ_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_idx;
   logic [DW-1:0]               new_dl;
   logic                        cur_live;
   logic                        cur_expired;
   logic                        rsp_free;

   assign cur_live    = live_ff[idx_ff];
   assign cur_expired = cur_live && ({1'b0, now_ff} >= dl_rd_ff);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign new_dl      = DW'(now_ff) + DW'(emb_ff);
   assign wr_idx      = free_ff ? free_idx_ff : old_idx_ff;
   assign wr_en       = cmd.finish_single && (type_ff == ept_pkg::REQ_ADD) && !found_ff;

   assign stat.is_expire = (type_ff == ept_pkg::REQ_EXPIRE);
   assign stat.last_slot = (idx_ff == IDX_W'(POOL_DEPTH - 1));
   assign stat.n_zero    = (n_ff == '0);
   assign stat.emit_hit  = cur_expired;
   assign stat.emit_last = ((emitted_ff + MW'(1)) == n_ff);
   assign stat.rsp_free  = rsp_free;

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[idx_ff];
      dl_rd_ff  <= dl_mem[idx_ff];
      if (wr_en) begin
         key_mem[wr_idx] <= key_ff;
         dl_mem[wr_idx]  <= new_dl;
      end
   end

   always_comb begin
      type_in       = type_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      lim_in        = lim_ff;
      emb_in        = csr_wr_en ? csr_wr_data : emb_ff;
      live_in       = live_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      free_in       = free_ff;
      found_idx_in  = found_idx_ff;
      free_idx_in   = free_idx_ff;
      old_idx_in    = old_idx_ff;
      old_dl_in     = old_dl_ff;
      n_in          = n_ff;
      emitted_in    = emitted_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.load_req) begin
         type_in    = req_type;
         key_in     = {req_key_w3, req_key_w2, req_key_w1, req_key_w0};
         now_in     = req_now_secs;
         lim_in     = (req_max_count > ept_pkg::MAX_EMIT) ? ept_pkg::MAX_EMIT
                                                          : req_max_count;
         idx_in     = '0;
         found_in   = 1'b0;
         free_in    = 1'b0;
         old_idx_in = '0;
         old_dl_in  = '1;
         n_in       = '0;
         emitted_in = '0;
      end
      if (cmd.clr_scan) begin
         idx_in = '0;
      end
      if (cmd.next_slot) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.eval_lookup) begin
         if (cur_live && (key_rd_ff == key_ff) && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = idx_ff;
         end
         if (!cur_live && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = idx_ff;
         end
         if (cur_live && (dl_rd_ff < old_dl_ff)) begin
            old_dl_in  = dl_rd_ff;
            old_idx_in = idx_ff;
         end
      end
      if (cmd.eval_count && cur_expired && (n_ff < lim_ff)) begin
         n_in = n_ff + MW'(1);
      end
      if (cmd.eval_emit) begin
         live_in[idx_ff] = 1'b0;
         cnt_in          = cnt_ff - CNT_W'(1);
         emitted_in      = emitted_ff + MW'(1);
         rsp_valid_in    = 1'b1;
         rsp_status_in   = ept_pkg::ST_INSERTED;
         rsp_hit_in      = 1'b1;
         rsp_key_in      = key_rd_ff;
         rsp_occ_in      = ept_pkg::OCC_W'(cnt_ff + CNT_W'(emitted_ff) - CNT_W'(n_ff));
         rsp_last_in     = stat.emit_last;
      end
      if (cmd.finish_single) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ept_pkg::ST_INSERTED;
         rsp_hit_in    = 1'b0;
         rsp_key_in    = '0;
         rsp_last_in   = 1'b1;
         case (type_ff)
            ept_pkg::REQ_ADD: begin
               if (found_ff) begin
                  rsp_status_in = ept_pkg::ST_DUP;
               end else begin
                  live_in[wr_idx] = 1'b1;
                  if (free_ff) begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end else begin
                     rsp_status_in = ept_pkg::ST_EVICTED;
                  end
               end
            end
            ept_pkg::REQ_REMOVE: begin
               rsp_hit_in = found_ff;
               if (found_ff) begin
                  live_in[found_idx_ff] = 1'b0;
                  cnt_in                = cnt_ff - CNT_W'(1);
               end
            end
            ept_pkg::REQ_CONTAINS: begin
               rsp_hit_in = found_ff;
            end
            default: begin
               rsp_hit_in = 1'b0;
            end
         endcase
         rsp_occ_in = ept_pkg::OCC_W'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emb_ff       <= ept_pkg::EMBARGO_RESET;
         live_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emb_ff       <= emb_in;
         live_ff      <= live_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      key_ff        <= key_in;
      now_ff        <= now_in;
      lim_ff        <= lim_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      free_ff       <= free_in;
      found_idx_ff  <= found_idx_in;
      free_idx_ff   <= free_idx_in;
      old_idx_ff    <= old_idx_in;
      old_dl_ff     <= old_dl_in;
      n_ff          <= n_in;
      emitted_ff    <= emitted_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_out_w0    = rsp_key_ff[WW-1:0];
   assign rsp_out_w1    = rsp_key_ff[2*WW-1:WW];
   assign rsp_out_w2    = rsp_key_ff[3*WW-1:2*WW];
   assign rsp_out_w3    = rsp_key_ff[4*WW-1:3*WW];
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

/* hdl/embargo_pool_table.sv */
// Embargo pool table top level: controller plus datapath.
// Depends on ept_pkg, ept_ctrl, ept_datapath.
//
//   channel  handshake               payload
//   req      req_valid / req_ready   req_type, req_key_w0..3, source, now, max
//   rsp      rsp_valid / rsp_ready   rsp_status, rsp_hit, rsp_out_w0..3, occ, last
//   csr      csr_wr_en               csr_wr_data (embargo seconds)
//
// Add, remove and contains walk every slot, a read state then a compare state per
// slot, set by the single read port of the slot memories.
// Expire walks the slots twice: it counts expired slots (up to the max count),
// then, if any were counted, emits them up to the last counted expired slot.
// Reset clears live bits and count and sets the embargo to 30; no clearing pass.
// A held result stalls the final response and the emit walk; a new request is taken only when the walk is done.
module embargo_pool_table #(
   parameter int POOL_DEPTH = ept_pkg::POOL_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [ept_pkg::EMB_W-1:0]     csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [ept_pkg::WORD_W-1:0]    req_key_w0,
   input  logic [ept_pkg::WORD_W-1:0]    req_key_w1,
   input  logic [ept_pkg::WORD_W-1:0]    req_key_w2,
   input  logic [ept_pkg::WORD_W-1:0]    req_key_w3,
   input  logic [ept_pkg::TIME_W-1:0]    req_source_peer,
   input  logic [ept_pkg::TIME_W-1:0]    req_now_secs,
   input  logic [ept_pkg::MAXC_W-1:0]    req_max_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_hit,
   output logic [ept_pkg::WORD_W-1:0]    rsp_out_w0,
   output logic [ept_pkg::WORD_W-1:0]    rsp_out_w1,
   output logic [ept_pkg::WORD_W-1:0]    rsp_out_w2,
   output logic [ept_pkg::WORD_W-1:0]    rsp_out_w3,
   output logic [ept_pkg::OCC_W-1:0]     rsp_occupancy,
   output logic                          rsp_last
);

   ept_pkg::cmd_type  cmd;
   ept_pkg::stat_type stat;

   ept_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ept_datapath #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_type      (req_type),
      .req_key_w0    (req_key_w0),
      .req_key_w1    (req_key_w1),
      .req_key_w2    (req_key_w2),
      .req_key_w3    (req_key_w3),
      .req_now_secs  (req_now_secs),
      .req_max_count (req_max_count),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_hit       (rsp_hit),
      .rsp_out_w0    (rsp_out_w0),
      .rsp_out_w1    (rsp_out_w1),
      .rsp_out_w2    (rsp_out_w2),
      .rsp_out_w3    (rsp_out_w3),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last)
   );

endmodule

/* hdl/ept_checker.sv */
// Port-level checker for the embargo pool table, bound to the top level.
// Depends on ept_pkg and embargo_pool_table_macros.svh.
`include "embargo_pool_table_macros.svh"

module ept_checker #(
   parameter int POOL_DEPTH = ept_pkg::POOL_DEPTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_status,
   input logic                          rsp_hit,
   input logic [ept_pkg::WORD_W-1:0]    rsp_out_w0,
   input logic [ept_pkg::OCC_W-1:0]     rsp_occupancy,
   input logic                          rsp_last
);

   `EPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_w0) && $stable(rsp_last), "rsp beat changed while stalled")
   `EPT_ASSERT_NOW(a_occ_bound, rsp_valid, 32'(rsp_occupancy) <= POOL_DEPTH, "occupancy above pool depth")
   `EPT_ASSERT_NOW(a_add_single, rsp_valid && (rsp_status != ept_pkg::ST_INSERTED), !rsp_hit && rsp_last, "add status on a hit or non-final beat")
   `EPT_ASSERT_NOW(a_miss_single, rsp_valid && !rsp_hit, (rsp_out_w0 == '0) && rsp_last, "miss beat carries key or is not final")

endmodule

bind embargo_pool_table ept_checker #(.POOL_DEPTH(POOL_DEPTH)) u_ept_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_hit       (rsp_hit),
   .rsp_out_w0    (rsp_out_w0),
   .rsp_occupancy (rsp_occupancy),
   .rsp_last      (rsp_last)
);
